// ===== src/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_0_7   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_8_15  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_16_23 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_24_31 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_LEN   = 3'd4;

  // Signature storage: four 64-bit words, byte 0 in the low bits
  localparam int unsigned SIG_WORDS = 4;
  localparam int unsigned SIG_BITS  = SIG_WORDS * CFG_DATA_W;

  // Signature length field
  localparam int unsigned LEN_W = 6;

  // Signature byte that matches any data byte
  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  // Result offset width
  localparam int unsigned START_W = 32;

  typedef struct packed {
    logic               match_here;
    logic [START_W-1:0] match_start;
    logic               found;
  } res_t;

endpackage : wbps_pkg

// ===== src/wbps_match.sv =====
// ----------------------------------------------------------------------------
// wbps_match
// Parallel wildcard compare of the byte window against the signature.
// ----------------------------------------------------------------------------
module wbps_match #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic [wbps_pkg::SIG_BITS-1:0] sig_bytes_i,
  input  logic [8*MAX_BYTES-1:0]        win_i,
  input  logic [wbps_pkg::LEN_W-1:0]    len_i,
  output logic                          hit_o
);
  import wbps_pkg::*;

  localparam int unsigned IDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  logic [7:0]       sig_a [MAX_BYTES];
  logic [LEN_W-1:0] sig_idx [MAX_BYTES];
  logic [MAX_BYTES-1:0] lane_ok;

  // Split the signature into bytes
  always_comb begin
    for (int j = 0; j < MAX_BYTES; j++) begin
      sig_a[j] = sig_bytes_i[8*j +: 8];
    end
  end

  // Window age k lines up with signature byte len-1-k
  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      sig_idx[k] = len_i - LEN_W'(k) - LEN_W'(1);
      if (LEN_W'(k) >= len_i) begin
        lane_ok[k] = 1'b1;
      end else begin
        lane_ok[k] = (sig_a[sig_idx[k][IDX_W-1:0]] == WILDCARD_BYTE) ||
                     (sig_a[sig_idx[k][IDX_W-1:0]] == win_i[8*k +: 8]);
      end
    end
  end

  assign hit_o = &lane_ok;

endmodule : wbps_match

// ===== src/wbps_skid.sv =====
// ----------------------------------------------------------------------------
// wbps_skid
// Two-entry result buffer: output register plus one skid entry.
// ----------------------------------------------------------------------------
module wbps_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  wbps_pkg::res_t   push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output wbps_pkg::res_t   pop_data
);
  import wbps_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_data_r, main_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic pop;
  logic push;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_data   = main_data_r;
  assign pop        = main_valid_r && pop_ready;
  assign push       = push_valid && !skid_valid_r;

  // Move transactions between the skid entry and the output register
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_data_nxt = push_data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload holds no reset
  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule : wbps_skid

// ===== src/wildcard_byte_pattern_scan_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan_core
// Streaming search for the first wildcard byte signature match in a region.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a region arrive on the in_ channel (valid/ready), the last one
//   flagged by in_region_end. Each accepted byte gives exactly one result
//   transaction on the out_ channel: match_here, match_start and found.
//   The signature (four 64-bit words, byte 0 lowest) and its length are
//   written through cfg_we/cfg_index/cfg_wdata while the block is idle.
//   A signature byte of 0x3F matches any data byte.
// Timing:
//   A byte accepted at one edge has its result in the output register
//   after that edge, or in the skid entry if the register is full. One byte
//   per cycle is sustained while the receiver keeps up; the window compare is
//   fully parallel and the window, counter and found flag update in the same cycle.
// Stall:
//   A two-entry output buffer keeps accepting while one result waits; in_ready
//   drops only when both entries are full.
// Reset:
//   Synchronous, active low. Clears the counter, found flag, buffer state and
//   the signature registers; the signature length resets to one.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_core #(
  parameter int unsigned MAX_SIGNATURE_BYTES = 32,
  parameter int unsigned OFFSET_BITS         = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_region_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_match_here,
  output logic [wbps_pkg::START_W-1:0]       out_match_start,
  output logic                               out_found
);
  import wbps_pkg::*;

  // Configuration registers
  logic [CFG_DATA_W-1:0] sig_r [SIG_WORDS];
  logic [LEN_W-1:0]      len_r;
  logic [SIG_BITS-1:0]   sig_flat;
  logic [LEN_W-1:0]      len_act;

  // Scan state
  logic [7:0]             win_r [MAX_SIGNATURE_BYTES];
  logic [8*MAX_SIGNATURE_BYTES-1:0] win_new;
  logic [OFFSET_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [OFFSET_BITS-1:0] first_start_r, first_start_nxt;
  logic                   found_r, found_nxt;
  logic [OFFSET_BITS-1:0] start_val;

  logic accept;
  logic cmp_hit;
  logic hit;
  logic pos_ok;
  res_t res;
  res_t out_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < SIG_WORDS; w++) begin
        sig_r[w] <= '0;
      end
      len_r <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIG_0_7:   sig_r[0] <= cfg_wdata;
        REG_SIG_8_15:  sig_r[1] <= cfg_wdata;
        REG_SIG_16_23: sig_r[2] <= cfg_wdata;
        REG_SIG_24_31: sig_r[3] <= cfg_wdata;
        REG_SIG_LEN:   len_r    <= cfg_wdata[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    for (int w = 0; w < SIG_WORDS; w++) begin
      sig_flat[CFG_DATA_W*w +: CFG_DATA_W] = sig_r[w];
    end
  end

  // Clamp the length to 1..MAX_SIGNATURE_BYTES
  always_comb begin
    if (len_r == '0) begin
      len_act = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_SIGNATURE_BYTES)) begin
      len_act = LEN_W'(MAX_SIGNATURE_BYTES);
    end else begin
      len_act = len_r;
    end
  end

  // Window with the incoming byte shifted in at the newest end
  always_comb begin
    win_new[7:0] = in_data_byte;
    for (int k = 1; k < MAX_SIGNATURE_BYTES; k++) begin
      win_new[8*k +: 8] = win_r[k-1];
    end
  end

  wbps_match #(
    .MAX_BYTES (MAX_SIGNATURE_BYTES)
  ) u_match (
    .sig_bytes_i (sig_flat),
    .win_i       (win_new),
    .len_i       (len_act),
    .hit_o       (cmp_hit)
  );

  assign accept = in_valid && in_ready;
  assign pos_ok = bytes_seen_r >= OFFSET_BITS'(len_act - LEN_W'(1));
  assign hit    = !found_r && pos_ok && cmp_hit;
  assign start_val = hit ? (bytes_seen_r - OFFSET_BITS'(len_act - LEN_W'(1)))
                         : first_start_r;

  // Form the result and the next region state
  always_comb begin
    res.match_here  = hit;
    res.found       = found_r || hit;
    res.match_start = res.found ? START_W'(start_val) : '0;

    if (in_region_end) begin
      bytes_seen_nxt  = '0;
      found_nxt       = 1'b0;
      first_start_nxt = '0;
    end else begin
      bytes_seen_nxt  = (bytes_seen_r == '1) ? bytes_seen_r
                                             : bytes_seen_r + OFFSET_BITS'(1);
      found_nxt       = found_r || hit;
      first_start_nxt = start_val;
    end
  end

  // Advance region state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= '0;
      found_r       <= 1'b0;
      first_start_r <= '0;
    end else if (accept) begin
      bytes_seen_r  <= bytes_seen_nxt;
      found_r       <= found_nxt;
      first_start_r <= first_start_nxt;
    end
  end

  // Shift the byte window; entries older than the count are never compared
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_SIGNATURE_BYTES; k++) begin
        win_r[k] <= win_new[8*k +: 8];
      end
    end
  end

  wbps_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_data)
  );

  assign out_match_here  = out_data.match_here;
  assign out_match_start = out_data.match_start;
  assign out_found       = out_data.found;

endmodule : wildcard_byte_pattern_scan_core

// ===== src/wbps_checker.sv =====
// ----------------------------------------------------------------------------
// wbps_checker
// Port-level checks on the scanner's result channel and flow control.
// ----------------------------------------------------------------------------
module wbps_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_match_here,
  input logic [wbps_pkg::START_W-1:0]   out_match_start,
  input logic                           out_found
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_match_here) &&
      $stable(out_match_start) && $stable(out_found))
    else $error("result payload changed while stalled");

  // A match always comes with the found flag
  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_here |-> out_found)
    else $error("match reported without found");

  // No start offset until a match is found
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_start == '0)
    else $error("start offset set without a match");

  // Back-pressure only with a result waiting
  a_ready_buf: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule : wbps_checker

bind wildcard_byte_pattern_scan_core wbps_checker u_wbps_checker (.*);

// ===== dv/tb_wildcard_byte_pattern_scan_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scan_core
// Self-checking bench for the wildcard byte signature scanner. Each accepted
// byte is run through a bit-accurate predictor of the window compare, the
// byte counter and the sticky found flag, and every result transaction is
// checked field by field against the oldest prediction. Stimulus mixes
// planted, corrupted and cut-off signatures with noise, under bursty input
// and a stalling receiver, across several signature settings.
// ----------------------------------------------------------------------------

// Predicts the scanner's results and holds those not yet seen on the output
class scan_scoreboard;
  logic [wbps_pkg::CFG_DATA_W-1:0] sig_word [wbps_pkg::SIG_WORDS];
  logic [wbps_pkg::LEN_W-1:0]      len_reg;
  logic [7:0]                      window [wbps_pkg::SIG_BITS/8];
  logic [wbps_pkg::START_W-1:0]    bytes_seen;
  logic                            found;
  logic [wbps_pkg::START_W-1:0]    first_start;
  wbps_pkg::res_t                  pending_results [$];
  int unsigned                     mismatches;

  function new();
    foreach (sig_word[i]) sig_word[i] = '0;
    len_reg    = 1;
    mismatches = 0;
    clear_region();
  endfunction

  function void clear_region();
    foreach (window[i]) window[i] = '0;
    bytes_seen  = '0;
    found       = 1'b0;
    first_start = '0;
  endfunction

  // Mirror a register write; unmapped indexes have no effect
  function void write_reg(logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                          logic [wbps_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      wbps_pkg::REG_SIG_0_7:   sig_word[0] = data;
      wbps_pkg::REG_SIG_8_15:  sig_word[1] = data;
      wbps_pkg::REG_SIG_16_23: sig_word[2] = data;
      wbps_pkg::REG_SIG_24_31: sig_word[3] = data;
      wbps_pkg::REG_SIG_LEN:   len_reg = data[wbps_pkg::LEN_W-1:0];
      default: ;
    endcase
  endfunction

  // Zero acts as one, anything above the window size acts as the window size
  function int unsigned active_len();
    if (len_reg == 0) return 1;
    if (len_reg > wbps_pkg::SIG_BITS/8) return wbps_pkg::SIG_BITS/8;
    return len_reg;
  endfunction

  function logic [7:0] sig_byte(int unsigned j);
    return sig_word[j/8][8*(j%8) +: 8];
  endfunction

  // Advance the window by one byte and queue the result it causes
  function void note_byte(logic [7:0] data, logic last);
    int unsigned                  len;
    logic [wbps_pkg::START_W-1:0] pos;
    logic                         hit;
    logic                         ok;
    wbps_pkg::res_t               res;
    len = active_len();
    pos = bytes_seen;
    hit = 1'b0;
    for (int i = wbps_pkg::SIG_BITS/8 - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = data;
    // Saturate the offset counter (not reachable in a run of this length)
    if (bytes_seen != '1) bytes_seen++;
    if (!found && pos >= len - 1) begin
      ok = 1'b1;
      // Signature byte 0 lines up with the oldest byte of the match
      for (int j = 0; j < len; j++) begin
        if (sig_byte(j) != wbps_pkg::WILDCARD_BYTE && sig_byte(j) != window[len-1-j])
          ok = 1'b0;
      end
      if (ok) begin
        hit         = 1'b1;
        found       = 1'b1;
        first_start = pos - wbps_pkg::START_W'(len - 1);
      end
    end
    res.match_here  = hit;
    res.match_start = found ? first_start : '0;
    res.found       = found;
    pending_results.push_back(res);
    if (last) clear_region();
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    // Keep the log short when things go badly wrong
    if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Compare one result transaction with the oldest prediction
  task check_result(wbps_pkg::res_t got);
    wbps_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h with nothing pending", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.match_here !== want.match_here)
      report_mismatch($sformatf("match_here %b, predicted %b", got.match_here,
                                want.match_here));
    if (got.match_start !== want.match_start)
      report_mismatch($sformatf("match_start %0d, predicted %0d", got.match_start,
                                want.match_start));
    if (got.found !== want.found)
      report_mismatch($sformatf("found %b, predicted %b", got.found, want.found));
  endtask

  function int unsigned outstanding();
    return pending_results.size();
  endfunction
endclass

module tb_wildcard_byte_pattern_scan_core;
  import wbps_pkg::*;

  localparam int unsigned SIG_MAX        = SIG_BITS / 8;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASES         = 10;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned PRESSURE_PHASE = 4;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_LAST = '1;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_PATTERN} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_data_byte;
  logic                  in_region_end;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_match_here;
  logic [START_W-1:0]    out_match_start;
  logic                  out_found;

  scan_scoreboard sb;

  logic [7:0]  cur_sig [SIG_MAX];
  int unsigned cur_len;
  logic [7:0]  region_bytes [$];
  int unsigned burst_left;
  int unsigned items_sent;
  bit          gapless;
  bit          hold_request;
  rx_mode_t    rx_mode;

  wildcard_byte_pattern_scan_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_region_end   (in_region_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_here  (out_match_here),
    .out_match_start (out_match_start),
    .out_found       (out_found)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data_byte, in_region_end);
      if (out_valid && out_ready)
        sb.check_result(res_t'({out_match_here, out_match_start, out_found}));
    end
  end

  // End the run if no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Receiver: stall on its own pattern, or hold off for a long stretch on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned rx_tick;
    hold_left = 0;
    rx_tick   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ready   <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
          default:   out_ready <= ((rx_tick % 7) >= 3);
        endcase
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Stop offering, wait until every predicted result has come out, then let
  // the pipe empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(logic [7:0] data, logic last);
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data_byte  <= data;
    in_region_end <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  function automatic logic [7:0] filler();
    if ($urandom_range(0, 1) != 0) return cur_sig[$urandom_range(0, cur_len - 1)];
    return 8'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] sig_word_of(int unsigned w);
    logic [CFG_DATA_W-1:0] word;
    for (int b = 0; b < 8; b++) word[8*b +: 8] = cur_sig[8*w + b];
    return word;
  endfunction

  // Append the first count signature bytes, wildcards filled at random,
  // optionally with one bit flipped somewhere
  task automatic push_signature(int unsigned count, bit corrupt);
    int unsigned bad;
    logic [7:0]  b;
    bad = corrupt ? $urandom_range(0, count - 1) : 0;
    for (int j = 0; j < count; j++) begin
      b = (cur_sig[j] == WILDCARD_BYTE) ? 8'($urandom) : cur_sig[j];
      if (corrupt && j == bad) b ^= 8'(1 << $urandom_range(0, 7));
      region_bytes.push_back(b);
    end
  endtask

  // Build one region: mostly planted matches, some broken ones, some noise
  task automatic make_region();
    int unsigned kind;
    region_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      repeat ($urandom_range(0, 12)) region_bytes.push_back(filler());
      push_signature(cur_len, 1'b0);
      // A second copy must not be reported
      if ($urandom_range(0, 3) == 0) push_signature(cur_len, 1'b0);
      repeat ($urandom_range(0, 12)) region_bytes.push_back(filler());
    end else if (kind < 75) begin
      repeat ($urandom_range(0, 12)) region_bytes.push_back(filler());
      push_signature(cur_len, 1'b1);
      repeat ($urandom_range(0, 12)) region_bytes.push_back(filler());
    end else if (kind < 85) begin
      // Signature cut off by the region end
      repeat ($urandom_range(0, 12)) region_bytes.push_back(filler());
      push_signature($urandom_range(0, cur_len - 1), 1'b0);
    end else if (kind < 97) begin
      repeat ($urandom_range(1, 40)) region_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(100, 300)) region_bytes.push_back(filler());
    end
    if (region_bytes.size() == 0) region_bytes.push_back(filler());
  endtask

  // Send the region in bursts with random gaps, unless running gapless
  task automatic send_region();
    for (int i = 0; i < region_bytes.size(); i++) begin
      send_byte(region_bytes[i], i == region_bytes.size() - 1);
      if (!gapless) begin
        if (burst_left == 0) begin
          idle_cycles($urandom_range(1, 8));
          burst_left = $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end
    end
  endtask

  // Draw a fresh signature and write all four words and the length
  task automatic load_signature(int unsigned len_value, int unsigned wild_pct);
    int unsigned r;
    settle();
    for (int i = 0; i < SIG_MAX; i++) begin
      r = $urandom_range(0, 99);
      if (r < wild_pct)           cur_sig[i] = WILDCARD_BYTE;
      else if (r < wild_pct + 10) cur_sig[i] = 8'h00;
      else                        cur_sig[i] = 8'($urandom);
    end
    write_cfg(REG_SIG_0_7,   sig_word_of(0));
    write_cfg(REG_SIG_8_15,  sig_word_of(1));
    write_cfg(REG_SIG_16_23, sig_word_of(2));
    write_cfg(REG_SIG_24_31, sig_word_of(3));
    // Junk above the length field must be dropped
    write_cfg(REG_SIG_LEN, ({$urandom, $urandom} & ~CFG_DATA_W'(6'h3F))
                           | CFG_DATA_W'(len_value));
    cur_len = sb.active_len();
  endtask

  initial begin : stimulus
    int unsigned len_value;
    int unsigned target;
    int unsigned r;
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_region_end = 1'b0;
    hold_request  = 1'b0;
    rx_mode       = RX_ALWAYS;
    gapless       = 1'b1;
    burst_left    = 0;
    items_sent    = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset signature is a single 0x00 byte: first zero matches, later ones do not
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    // Length zero acts as one; a lone wildcard matches anything
    settle();
    write_cfg(REG_SIG_0_7, CFG_DATA_W'(WILDCARD_BYTE));
    write_cfg(REG_SIG_LEN, '0);
    send_byte(8'hA5, 1'b1);

    // Three-byte signature with a wildcard in the middle
    settle();
    write_cfg(REG_SIG_0_7, {40'h0, 8'h34, WILDCARD_BYTE, 8'h12});
    write_cfg(REG_SIG_LEN, CFG_DATA_W'(3));
    // Writes to unmapped indexes must leave the signature alone
    for (int i = REG_SIG_LEN + 1; i <= REG_IDX_LAST; i++)
      write_cfg(CFG_IDX_W'(i), {$urandom, $urandom});
    send_byte(8'h12, 1'b0);
    send_byte(WILDCARD_BYTE, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h34, 1'b1);
    // Match split across a region end, and a region shorter than the signature
    send_byte(8'h12, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h34, 1'b1);
    // 0x3F in the data is no wildcard
    send_byte(WILDCARD_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h34, 1'b1);

    // Random phases, the length extremes first
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: len_value = SIG_MAX;
        1: len_value = 63;
        2: len_value = 0;
        3: len_value = 1;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 6)      len_value = $urandom_range(2, 6);
          else if (r < 9) len_value = $urandom_range(7, SIG_MAX - 1);
          else            len_value = $urandom_range(SIG_MAX + 1, 63);
        end
      endcase
      load_signature(len_value, $urandom_range(0, 40));
      rx_mode = rx_mode_t'(p % 4);
      gapless = (p == 0) || (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      // Hold the receiver off while bytes keep coming, to fill the block
      if (p == PRESSURE_PHASE) hold_request = 1'b1;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        make_region();
        send_region();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    settle();
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.outstanding()));
    if (sb.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wbps_pkg.sv
src/wbps_match.sv
src/wbps_skid.sv
src/wildcard_byte_pattern_scan_core.sv
src/wbps_checker.sv
dv/tb_wildcard_byte_pattern_scan_core.sv
